// ===== hdl/svcs_pkg.sv =====
// Shared types and constants of the servo velocity command shaper.
// Depends on nothing; the front, back and top files refer to it by scoped names.
package svcs_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_TARGET_X  = 3'd0,
		REG_TARGET_Y  = 3'd1,
		REG_TARGET_Z  = 3'd2,
		REG_ARRIVE_TH = 3'd3,
		REG_RATIO_DIV = 3'd4,
		REG_SPEED_LO  = 3'd5,
		REG_SPEED_HI  = 3'd6
	} reg_idx_t;

	// Reset values of the unsigned registers
	localparam logic [30:0] ARRIVE_TH_RST = 31'd83886;
	localparam logic [7:0]  RATIO_DIV_RST = 8'd10;
	localparam logic [30:0] SPEED_LO_RST  = 31'd419430;
	localparam logic [30:0] SPEED_HI_RST  = 31'd1677722;

	// Queue depths between front and back, and in front of the result port
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	// Per-word sign and classification flags
	typedef struct packed {
		logic arrived;
		logic negx;   // x error below zero: x velocity comes out positive
		logic negy;   // y error below zero: y velocity comes out positive
		logic posz;   // z error above zero: z velocity comes out positive
	} flags_t;

	// Shaping settings used by the back part
	typedef struct packed {
		logic [7:0]  ratio_divisor;
		logic [30:0] speed_lo;
		logic [30:0] speed_hi;
	} shape_cfg_t;

endpackage

// ===== hdl/svcs_fifo.sv =====
// Small flip-flop queue with registered count, used between front and back and at the output.
// Depends on nothing.
module svcs_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/svcs_front.sv =====
// Front part: error, magnitudes, squared length and arrival test, four stages.
// Depends on svcs_pkg.
module svcs_front #(
	parameter int P = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [P-1:0] cur_x,
	input  logic signed [P-1:0] cur_y,
	input  logic signed [P-1:0] cur_z,
	input  logic signed [P-1:0] target_x,
	input  logic signed [P-1:0] target_y,
	input  logic signed [P-1:0] target_z,
	input  logic [30:0]         arrive_threshold,
	output logic                out_valid,
	output logic [2:0][P:0]     out_mag,
	output svcs_pkg::flags_t    out_flags
);
	localparam int W = P + 1;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [W-1:0] e_s1 [3];
	logic [W-1:0] mag_s2 [3];
	logic [W-1:0] mag_s3 [3];
	logic [W-1:0] mag_s4 [3];
	logic negx_s2, negy_s2, posz_s2;
	logic negx_s3, negy_s3, posz_s3;
	logic negx_s4, negy_s4, posz_s4;
	logic small_s3, small_s4;
	logic [61:0] sq_s3 [3];
	logic [61:0] thsq_s3;
	logic [61:0] thsq_s4;
	logic [63:0] sum_s4;
	logic [63:0] mx [3];
	logic        small_c;

	// Widen magnitudes for the square stage
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mx[i] = 64'(mag_s2[i]);
		end
		small_c = (mx[0][63:31] == '0) && (mx[1][63:31] == '0) && (mx[2][63:31] == '0);
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			e_s1[0] <= {target_x[P-1], target_x} - {cur_x[P-1], cur_x};
			e_s1[1] <= {target_y[P-1], target_y} - {cur_y[P-1], cur_y};
			e_s1[2] <= {target_z[P-1], target_z} - {cur_z[P-1], cur_z};

			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= e_s1[i][W-1] ? (W'(0) - e_s1[i]) : e_s1[i];
			end
			negx_s2 <= e_s1[0][W-1];
			negy_s2 <= e_s1[1][W-1];
			posz_s2 <= !e_s1[2][W-1] && (e_s1[2] != '0);

			for (int i = 0; i < 3; i++) begin
				sq_s3[i]  <= 62'(mx[i][30:0]) * 62'(mx[i][30:0]);
				mag_s3[i] <= mag_s2[i];
			end
			thsq_s3  <= 62'(arrive_threshold) * 62'(arrive_threshold);
			small_s3 <= small_c;
			negx_s3  <= negx_s2;
			negy_s3  <= negy_s2;
			posz_s3  <= posz_s2;

			sum_s4   <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
			thsq_s4  <= thsq_s3;
			small_s4 <= small_s3;
			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= mag_s3[i];
			end
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			posz_s4 <= posz_s3;
		end
	end

	// Classify and hand the word to the queue
	always_comb begin
		out_valid         = v_s4;
		out_flags.arrived = small_s4 && (sum_s4 < {2'b00, thsq_s4});
		out_flags.negx    = negx_s4;
		out_flags.negy    = negy_s4;
		out_flags.posz    = posz_s4;
		for (int i = 0; i < 3; i++) begin
			out_mag[i] = mag_s4[i];
		end
	end

endmodule

// ===== hdl/svcs_back.sv =====
// Back part: divide by the ratio, pick the largest, rescale to the clamp, restore signs.
// Depends on svcs_pkg.
module svcs_back #(
	parameter int P = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [2:0][P:0]      in_mag,
	input  svcs_pkg::flags_t     in_flags,
	input  svcs_pkg::shape_cfg_t cfg,
	output logic                 out_valid,
	output logic [P-1:0]         vel_x,
	output logic [P-1:0]         vel_y,
	output logic [P-1:0]         vel_z,
	output logic                 arrived
);
	localparam int W  = P + 1;
	localparam int CB = 31;
	localparam logic [W-1:0] HALF = W'(1) << (P - 1);

	// Divider stages, one quotient bit per stage
	logic             dv_v     [W+1];
	logic [W-1:0]     dv_nq    [W+1][3];
	logic [7:0]       dv_rem   [W+1][3];
	logic [7:0]       dv_d     [W+1];
	svcs_pkg::flags_t dv_f     [W+1];

	// Largest-component stage
	logic             mx_v;
	logic [W-1:0]     mx_a     [3];
	logic [W-1:0]     mx_m;
	svcs_pkg::flags_t mx_f;

	// Scaling stages, one clamp bit per stage
	logic             sc_v     [CB+1];
	logic [W-1:0]     sc_a     [CB+1][3];
	logic [W-1:0]     sc_r     [CB+1][3];
	logic [CB-1:0]    sc_q     [CB+1][3];
	logic [W-1:0]     sc_m     [CB+1];
	logic [CB-1:0]    sc_c     [CB+1];
	logic             sc_scale [CB+1];
	svcs_pkg::flags_t sc_f     [CB+1];

	logic [7:0]   d_eff;
	logic [W-1:0] m_c;
	logic         lo_c, hi_c;
	logic [W-1:0] a_fin [3];
	logic         pos   [3];
	logic [P-1:0] v_out [3];

	assign d_eff = (cfg.ratio_divisor == '0) ? 8'd1 : cfg.ratio_divisor;

	// Load the divider from the queue head; arrived words divide by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_nq[0][i]  <= in_mag[i];
				dv_rem[0][i] <= '0;
			end
			dv_d[0] <= in_flags.arrived ? 8'd1 : d_eff;
			dv_f[0] <= in_flags;
		end
	end

	for (genvar k = 0; k < W; k++) begin : g_div
		logic [8:0] r2  [3];
		logic       ge  [3];
		logic [7:0] rn  [3];

		// Shift in one dividend bit, subtract where it fits
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				r2[i] = {dv_rem[k][i], dv_nq[k][i][W-1]};
				ge[i] = (r2[i] >= {1'b0, dv_d[k]});
				rn[i] = ge[i] ? 8'(r2[i] - {1'b0, dv_d[k]}) : r2[i][7:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (en) begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_nq[k+1][i]  <= {dv_nq[k][i][W-2:0], ge[i]};
					dv_rem[k+1][i] <= rn[i];
				end
				dv_d[k+1] <= dv_d[k];
				dv_f[k+1] <= dv_f[k];
			end
		end
	end

	// Pick the largest quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mx_v <= 1'b0;
		end else if (en) begin
			mx_v <= dv_v[W];
		end
	end

	always_comb begin
		m_c = (dv_nq[W][0] > dv_nq[W][1]) ? dv_nq[W][0] : dv_nq[W][1];
		m_c = (m_c > dv_nq[W][2]) ? m_c : dv_nq[W][2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mx_a[i] <= dv_nq[W][i];
			end
			mx_m <= m_c;
			mx_f <= dv_f[W];
		end
	end

	// Choose the clamp: the minimum test comes first
	always_comb begin
		lo_c = !mx_f.arrived && (mx_m != '0) && (64'(mx_m) < 64'(cfg.speed_lo));
		hi_c = !mx_f.arrived && (64'(mx_m) > 64'(cfg.speed_hi));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_v[0] <= 1'b0;
		end else if (en) begin
			sc_v[0] <= mx_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sc_a[0][i] <= mx_a[i];
				sc_r[0][i] <= '0;
				sc_q[0][i] <= '0;
			end
			sc_m[0] <= mx_m;
			sc_f[0] <= mx_f;
			priority if (lo_c) begin
				sc_c[0]     <= cfg.speed_lo;
				sc_scale[0] <= 1'b1;
			end else if (hi_c) begin
				sc_c[0]     <= cfg.speed_hi;
				sc_scale[0] <= 1'b1;
			end else begin
				sc_c[0]     <= cfg.speed_hi;
				sc_scale[0] <= 1'b0;
			end
		end
	end

	for (genvar j = 0; j < CB; j++) begin : g_scl
		logic [W+1:0]  t   [3];
		logic [W+1:0]  m1;
		logic [W+1:0]  m2;
		logic [W-1:0]  rn  [3];
		logic [1:0]    kq  [3];

		// Fold in one clamp bit: remainder doubles, adds a, loses up to 2m
		always_comb begin
			m1 = {2'b00, sc_m[j]};
			m2 = {1'b0, sc_m[j], 1'b0};
			for (int i = 0; i < 3; i++) begin
				t[i] = {1'b0, sc_r[j][i], 1'b0}
					+ (sc_c[j][CB-1-j] ? {2'b00, sc_a[j][i]} : '0);
				if (t[i] >= m2) begin
					rn[i] = W'(t[i] - m2);
					kq[i] = 2'd2;
				end else if (t[i] >= m1) begin
					rn[i] = W'(t[i] - m1);
					kq[i] = 2'd1;
				end else begin
					rn[i] = W'(t[i]);
					kq[i] = 2'd0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sc_v[j+1] <= 1'b0;
			end else if (en) begin
				sc_v[j+1] <= sc_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					sc_a[j+1][i] <= sc_a[j][i];
					sc_r[j+1][i] <= rn[i];
					sc_q[j+1][i] <= CB'({sc_q[j][i], 1'b0}) + CB'(kq[i]);
				end
				sc_m[j+1]     <= sc_m[j];
				sc_c[j+1]     <= sc_c[j];
				sc_scale[j+1] <= sc_scale[j];
				sc_f[j+1]     <= sc_f[j];
			end
		end
	end

	// Restore signs and saturate to the output range
	always_comb begin
		pos[0] = sc_f[CB].negx;
		pos[1] = sc_f[CB].negy;
		pos[2] = sc_f[CB].posz;
		for (int i = 0; i < 3; i++) begin
			a_fin[i] = sc_scale[CB] ? W'(sc_q[CB][i]) : sc_a[CB][i];
			if (pos[i]) begin
				v_out[i] = (a_fin[i] >= HALF) ? P'(HALF - 1'b1) : P'(a_fin[i]);
			end else begin
				v_out[i] = (a_fin[i] > HALF) ? P'(HALF) : P'(W'(0) - a_fin[i]);
			end
		end
	end

	assign out_valid = sc_v[CB];
	assign vel_x     = v_out[0];
	assign vel_y     = v_out[1];
	assign vel_z     = v_out[2];
	assign arrived   = sc_f[CB].arrived;

endmodule

// ===== hdl/servo_velocity_command_shaper.sv =====
// Top level of the servo velocity command shaper: settings, front, queues and back.
// Depends on svcs_pkg, svcs_fifo, svcs_front and svcs_back.
//
//  channel   handshake                 payload
//  ------    ---------                 -------
//  input     push / full               cur_x, cur_y, cur_z
//  result    pop / empty               vel_x, vel_y, vel_z, arrived
//  settings  cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word per cycle in and out, stalls aside; stages are pipeline registers only.
// Latency: 4 front stages, one queue slot, POS_WIDTH+35 back stages (one per quotient
// bit of the ratio divider, one per clamp bit of the rescaler), then the result queue.
// The front stalls only when the middle queue is full, the back only when the result
// queue is full. Reset clears valids and queue counts and presets the settings.
module servo_velocity_command_shaper #(
	parameter int POS_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic signed [POS_WIDTH-1:0] cur_x,
	input  logic signed [POS_WIDTH-1:0] cur_y,
	input  logic signed [POS_WIDTH-1:0] cur_z,
	output logic                        empty,
	input  logic                        pop,
	output logic signed [POS_WIDTH-1:0] vel_x,
	output logic signed [POS_WIDTH-1:0] vel_y,
	output logic signed [POS_WIDTH-1:0] vel_z,
	output logic                        arrived,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [2:0]                  cfg_index,
	input  logic [((POS_WIDTH > 31) ? POS_WIDTH : 31)-1:0] cfg_data
);
	localparam int P     = POS_WIDTH;
	localparam int W     = P + 1;
	localparam int MID_W = $bits(svcs_pkg::flags_t) + 3 * W;
	localparam int OUT_W = 3 * P + 1;

	logic signed [P-1:0]  target_x_q, target_y_q, target_z_q;
	logic [30:0]          arrive_th_q;
	svcs_pkg::shape_cfg_t shape_q;

	logic             en_front, en_back;
	logic             fr_valid;
	logic [2:0][P:0]  fr_mag;
	svcs_pkg::flags_t fr_flags;
	logic             mid_wr, mid_rd, mid_full, mid_empty;
	logic [MID_W-1:0] mid_rd_data;
	logic [2:0][P:0]  bk_mag;
	svcs_pkg::flags_t bk_flags;
	logic             bk_valid;
	logic [P-1:0]     bk_vx, bk_vy, bk_vz;
	logic             bk_arr;
	logic             out_wr, out_full;
	logic [OUT_W-1:0] out_rd_data;

	assign cfg_ready = 1'b1;

	// Write settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q            <= '0;
			target_y_q            <= '0;
			target_z_q            <= '0;
			arrive_th_q           <= svcs_pkg::ARRIVE_TH_RST;
			shape_q.ratio_divisor <= svcs_pkg::RATIO_DIV_RST;
			shape_q.speed_lo      <= svcs_pkg::SPEED_LO_RST;
			shape_q.speed_hi      <= svcs_pkg::SPEED_HI_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (svcs_pkg::reg_idx_t'(cfg_index))
				svcs_pkg::REG_TARGET_X:  target_x_q            <= cfg_data[P-1:0];
				svcs_pkg::REG_TARGET_Y:  target_y_q            <= cfg_data[P-1:0];
				svcs_pkg::REG_TARGET_Z:  target_z_q            <= cfg_data[P-1:0];
				svcs_pkg::REG_ARRIVE_TH: arrive_th_q           <= cfg_data[30:0];
				svcs_pkg::REG_RATIO_DIV: shape_q.ratio_divisor <= cfg_data[7:0];
				svcs_pkg::REG_SPEED_LO:  shape_q.speed_lo      <= cfg_data[30:0];
				svcs_pkg::REG_SPEED_HI:  shape_q.speed_hi      <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// Stall each side on its own queue
	assign en_front = !mid_full;
	assign full     = mid_full;
	assign en_back  = !out_full;

	svcs_front #(.P(P)) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en_front),
		.in_valid         (push && !full),
		.cur_x            (cur_x),
		.cur_y            (cur_y),
		.cur_z            (cur_z),
		.target_x         (target_x_q),
		.target_y         (target_y_q),
		.target_z         (target_z_q),
		.arrive_threshold (arrive_th_q),
		.out_valid        (fr_valid),
		.out_mag          (fr_mag),
		.out_flags        (fr_flags)
	);

	assign mid_wr = en_front && fr_valid;
	assign mid_rd = en_back && !mid_empty;

	svcs_fifo #(.DEPTH(svcs_pkg::MID_DEPTH), .WIDTH(MID_W)) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data ({fr_flags, fr_mag}),
		.rd_en   (mid_rd),
		.rd_data (mid_rd_data),
		.full    (mid_full),
		.empty   (mid_empty)
	);

	assign {bk_flags, bk_mag} = mid_rd_data;

	svcs_back #(.P(P)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_back),
		.in_valid  (!mid_empty),
		.in_mag    (bk_mag),
		.in_flags  (bk_flags),
		.cfg       (shape_q),
		.out_valid (bk_valid),
		.vel_x     (bk_vx),
		.vel_y     (bk_vy),
		.vel_z     (bk_vz),
		.arrived   (bk_arr)
	);

	assign out_wr = en_back && bk_valid;

	svcs_fifo #(.DEPTH(svcs_pkg::OUT_DEPTH), .WIDTH(OUT_W)) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data ({bk_arr, bk_vz, bk_vy, bk_vx}),
		.rd_en   (pop && !empty),
		.rd_data (out_rd_data),
		.full    (out_full),
		.empty   (empty)
	);

	assign {arrived, vel_z, vel_y, vel_x} = out_rd_data;

	// Neither queue takes a word while full
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_wr |-> !mid_full)
		else $error("middle queue written while full");

	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> !out_full)
		else $error("result queue written while full");

	// A stalled back part must not drain the middle queue
	a_back_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_full |-> !mid_rd)
		else $error("middle queue read while back part stalled");

endmodule
